>>> hdl/ost_pkg.sv
// ---------------------------------------------------------------------------
// ost_pkg: shared types and constants of the one-shot timer table
// Item structs for both channels, result kinds, operation codes, and the
// command and status groups between the controller and the datapath.
// ---------------------------------------------------------------------------
package ost_pkg;

    // operation codes of an input item
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_STARTED = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    // saturation point of the tick counter
    localparam logic [47:0] TICK_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic        op;
        logic [31:0] duration;
        logic [31:0] context_req;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  slot;
        logic [31:0] tag;
        logic [47:0] tick_now;
        logic        last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       idx_clr;
        logic       idx_inc;
        logic       claim;
        logic       mem_rd;
        logic       free_slot;
        logic       emit;
        logic [1:0] emit_kind;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic idx_busy;
        logic idx_last;
        logic expired;
        logic out_free;
        logic paused;
    } dp_stat_t;

endpackage

>>> hdl/ost_dpath.sv
// ---------------------------------------------------------------------------
// ost_dpath: datapath of the one-shot timer table
// Tick counter, busy bits, deadline and tag memories with a registered read
// port, the slot index, the pause register and the output register.
// ---------------------------------------------------------------------------
module ost_dpath
    import ost_pkg::*;
#(
    parameter int SLOTS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  logic      cfg_valid,
    input  logic      cfg_data,
    input  logic      out_stall,
    output logic      out_valid,
    output out_item_t out_item,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat
);

    localparam int SW = $clog2(SLOTS);
    localparam logic [SW-1:0] IDX_LAST = SW'(SLOTS - 1);

    logic            paused_reg;
    logic [47:0]     tick_reg;
    logic [47:0]     tick_next;
    logic [31:0]     dur_reg;
    logic [31:0]     ctx_reg;
    logic [SW-1:0]   idx_reg;
    logic [SLOTS-1:0] busy_reg;
    logic [48:0]     dl_mem [SLOTS];
    logic [31:0]     tag_mem [SLOTS];
    logic [48:0]     rd_dl_reg;
    logic [31:0]     rd_tag_reg;
    logic            out_valid_reg;
    out_item_t       out_item_reg;
    out_item_t       out_item_next;
    logic [SW+4:0]   idx_wide;

    // pause register, written over the configuration channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paused_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            paused_reg <= cfg_data;
        end
    end

    // saturating advance on an unpaused tick
    always_comb
    begin
        tick_next = tick_reg;
        if (in_item.op == OP_TICK && !paused_reg && tick_reg != TICK_MAX)
        begin
            tick_next = tick_reg + 48'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
        end
        else if (cmd.load_in)
        begin
            tick_reg <= tick_next;
        end
    end

    // input payload capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            dur_reg <= in_item.duration;
            ctx_reg <= in_item.context_req;
        end
    end

    // slot index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + SW'(1);
        end
    end

    // busy bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else if (cmd.claim)
        begin
            busy_reg[idx_reg] <= 1'b1;
        end
        else if (cmd.free_slot)
        begin
            busy_reg[idx_reg] <= 1'b0;
        end
    end

    // deadline and tag memories, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.claim)
        begin
            dl_mem[idx_reg]  <= {1'b0, tick_reg} + {17'd0, dur_reg};
            tag_mem[idx_reg] <= ctx_reg;
        end
        if (cmd.mem_rd)
        begin
            rd_dl_reg  <= dl_mem[idx_reg];
            rd_tag_reg <= tag_mem[idx_reg];
        end
    end

    // result assembly
    assign idx_wide = {5'd0, idx_reg};

    always_comb
    begin
        out_item_next.kind     = cmd.emit_kind;
        out_item_next.slot     = 5'd0;
        out_item_next.tag      = 32'd0;
        out_item_next.tick_now = tick_reg;
        out_item_next.last     = (cmd.emit_kind != KIND_EXPIRED);
        if (cmd.emit_kind == KIND_STARTED || cmd.emit_kind == KIND_EXPIRED)
        begin
            out_item_next.slot = idx_wide[4:0];
        end
        if (cmd.emit_kind == KIND_EXPIRED)
        begin
            out_item_next.tag = rd_tag_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // status towards the controller
    assign stat.idx_busy = busy_reg[idx_reg];
    assign stat.idx_last = (idx_reg == IDX_LAST);
    assign stat.expired  = ({1'b0, tick_reg} >= rd_dl_reg);
    assign stat.out_free = !out_valid_reg || !out_stall;
    assign stat.paused   = paused_reg;

endmodule

>>> hdl/ost_ctrl.sv
// ---------------------------------------------------------------------------
// ost_ctrl: controller of the one-shot timer table
// Walks the slots one at a time for a free slot on a start and for expired
// slots on an unpaused tick, and paces every result into the output register.
// ---------------------------------------------------------------------------
module ost_ctrl
    import ost_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_op,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FIND  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_CHECK = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cmd.idx_clr = 1'b1;
                    if (in_op == OP_START)
                    begin
                        state_next = S_FIND;
                    end
                    else if (stat.paused)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            // lowest free slot search
            S_FIND:
            begin
                if (!stat.idx_busy)
                begin
                    cmd.emit_kind = KIND_STARTED;
                    if (stat.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.claim  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.idx_last)
                begin
                    cmd.emit_kind = KIND_FULL;
                    if (stat.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            // expiry scan, fetch a busy slot
            S_SCAN:
            begin
                if (stat.idx_busy)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_CHECK;
                end
                else if (stat.idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            // deadline compare on the fetched entry
            S_CHECK:
            begin
                cmd.emit_kind = KIND_EXPIRED;
                if (!stat.expired || stat.out_free)
                begin
                    if (stat.expired)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.free_slot = 1'b1;
                    end
                    if (stat.idx_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_DONE:
            begin
                cmd.emit_kind = KIND_DONE;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/one_shot_timer_table.sv
// ---------------------------------------------------------------------------
// one_shot_timer_table: table of one-shot timers on a saturating tick counter
// Start items claim the lowest free slot, unpaused ticks advance time and
// report every expired slot in ascending order followed by a tick-done marker.
// ---------------------------------------------------------------------------
// One item is worked on at a time; the input stalls from the transfer of an
// item until its final result sits in the output register, and the next item
// is taken while that result waits. The slot walk visits the slots one at a
// time and the deadline memory has a single registered read port, so on an
// unpaused tick each busy slot is fetched in S_SCAN and then compared in
// S_CHECK; a paused tick skips the walk and reports only the tick-done marker.
// A result that meets a stalled output holds the walk. The configuration
// channel is always ready and writes the pause bit.
module one_shot_timer_table
    import ost_pkg::*;
#(
    parameter int SLOTS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    ost_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_item.op),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ost_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> hdl/ost_check.sv
// ---------------------------------------------------------------------------
// ost_check: port-level checks of the one-shot timer table
// Watches the channels of the top level and is bound to every instance.
// ---------------------------------------------------------------------------
module ost_check
    import ost_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_item,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    // a stalled input item holds until its transfer
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_item))
        else $error("stalled input item changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // an accepted item makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after a transfer");

    // no result appears while the block waits for an item
    a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && !out_valid |=> !out_valid)
        else $error("result produced without an item at work");

    // only an expiry report leaves more results to follow
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.last == (out_item.kind != KIND_EXPIRED)))
        else $error("last flag does not match result kind");

endmodule

bind one_shot_timer_table ost_check u_ost_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

>>> tb/tb_one_shot_timer_table.sv
// ---------------------------------------------------------------------------
// tb_one_shot_timer_table: self-checking bench for the one-shot timer table
// Drives start and tick items through the stall handshake, keeps its own
// copy of the timer table and tick counter, and checks every result in order.
// Runs a short directed part, then random phases across pause settings and
// idle patterns on both sides of the block.
// ---------------------------------------------------------------------------

// expected result store and timer table copy
class timer_scoreboard #(int SLOTS = 32);

    int unsigned errors;
    int unsigned n_items;
    int unsigned n_checked;
    int unsigned n_expired;
    int unsigned n_full;
    int unsigned n_held_ticks;
    int unsigned most_per_tick;

    bit          paused;
    bit [47:0]   tick_count;
    bit          slot_busy [SLOTS];
    bit [48:0]   deadline [SLOTS];
    bit [31:0]   slot_tag [SLOTS];

    ost_pkg::out_item_t due_results [$];

    function new();
        errors = 0;
        n_items = 0;
        n_checked = 0;
        n_expired = 0;
        n_full = 0;
        n_held_ticks = 0;
        most_per_tick = 0;
        paused = 1'b0;
        tick_count = '0;
        foreach (slot_busy[i])
        begin
            slot_busy[i] = 1'b0;
            deadline[i] = '0;
            slot_tag[i] = '0;
        end
    endfunction

    // queue one result stamped with the current tick
    function void queue_result(logic [1:0] kind, logic [4:0] slot, logic [31:0] tag,
                               logic last);
        ost_pkg::out_item_t r;
        r.kind = kind;
        r.slot = slot;
        r.tag = tag;
        r.tick_now = tick_count;
        r.last = last;
        due_results.push_back(r);
    endfunction

    // work out the results of an accepted input transfer
    function void note_item(ost_pkg::in_item_t it);
        int free_idx;
        int hits;
        n_items++;
        if (it.op == ost_pkg::OP_START)
        begin
            // lowest free slot wins
            free_idx = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (!slot_busy[i])
                    free_idx = i;
            end
            if (free_idx < 0)
            begin
                n_full++;
                queue_result(ost_pkg::KIND_FULL, '0, '0, 1'b1);
            end
            else
            begin
                slot_busy[free_idx] = 1'b1;
                deadline[free_idx] = {1'b0, tick_count} + {17'd0, it.duration};
                slot_tag[free_idx] = it.context_req;
                queue_result(ost_pkg::KIND_STARTED, 5'(free_idx), '0, 1'b1);
            end
        end
        else
        begin
            hits = 0;
            if (paused)
                n_held_ticks++;
            else
            begin
                // saturating advance, then expire in ascending slot order
                if (tick_count != ost_pkg::TICK_MAX)
                    tick_count++;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_busy[i] && {1'b0, tick_count} >= deadline[i])
                    begin
                        queue_result(ost_pkg::KIND_EXPIRED, 5'(i), slot_tag[i], 1'b0);
                        slot_busy[i] = 1'b0;
                        hits++;
                    end
                end
            end
            n_expired += hits;
            if (hits > most_per_tick)
                most_per_tick = hits;
            queue_result(ost_pkg::KIND_DONE, '0, '0, 1'b1);
        end
    endfunction

    task report(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    // compare an output transfer with the oldest expectation
    task check_result(ost_pkg::out_item_t got);
        ost_pkg::out_item_t want;
        if (due_results.size() == 0)
        begin
            report($sformatf("result with nothing expected: kind %0d slot %0d tag %h",
                             got.kind, got.slot, got.tag));
            return;
        end
        want = due_results.pop_front();
        n_checked++;
        if (got.kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.slot !== want.slot)
            report($sformatf("slot %0d, expected %0d", got.slot, want.slot));
        if (got.tag !== want.tag)
            report($sformatf("tag %h, expected %h", got.tag, want.tag));
        if (got.tick_now !== want.tick_now)
            report($sformatf("tick_now %0d, expected %0d", got.tick_now, want.tick_now));
        if (got.last !== want.last)
            report($sformatf("last %b, expected %b", got.last, want.last));
    endtask

endclass

module tb_one_shot_timer_table;

    import ost_pkg::*;

    localparam int SLOTS = 32;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 60;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned cycle_count = 0;

    // per phase: sender idle, receiver stall, pause bit, share of starts, short timers
    int phase_send [NUM_PHASES] = '{0, 56, 0, 22, 0, 56, 0, 22};
    int phase_recv [NUM_PHASES] = '{0, 0, 56, 22, 0, 0, 56, 22};
    int phase_hold [NUM_PHASES] = '{0, 0, 1, 0, 0, 1, 0, 0};
    int phase_pct  [NUM_PHASES] = '{50, 45, 80, 35, 50, 85, 40, 50};
    int phase_fast [NUM_PHASES] = '{0, 0, 0, 0, 0, 1, 0, 0};

    timer_scoreboard #(SLOTS) sb;

    one_shot_timer_table #(
        .SLOTS(SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // output side: check each transfer, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, sb.due_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic op, input logic [31:0] dur, input logic [31:0] ctx);
        in_item_t it;
        it.op = op;
        it.duration = dur;
        it.context_req = ctx;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(it);
    endtask

    // random item; short timers make many expire on one tick
    task automatic random_item(input int start_pct, input int fast);
        logic [31:0] dur;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick >= 96)
            dur = $urandom;
        else if (fast != 0)
            dur = $urandom_range(0, 2);
        else if (pick < 8)
            dur = '0;
        else if (pick < 70)
            dur = $urandom_range(1, 40);
        else
            dur = $urandom_range(41, 300);
        send_item(($urandom_range(0, 99) < start_pct) ? OP_START : OP_TICK, dur, $urandom);
    endtask

    // hold the sender until every expected result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_pause(input logic value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.paused = value;
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_pause(1'b0);

        // zero and one tick timers, then one that never fires
        send_item(OP_START, 32'd0, 32'hFFFF_FFFF);
        send_item(OP_START, 32'd1, 32'h0000_0000);
        send_item(OP_START, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        // both short timers expire together, then a quiet tick
        send_item(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_TICK, 32'd0, 32'd0);
        send_item(OP_START, 32'd0, 32'h1234_5678);

        // paused: tick holds time, start still claims a slot
        write_pause(1'b1);
        send_item(OP_TICK, 32'd0, 32'd0);
        send_item(OP_TICK, 32'd7, 32'h5555_AAAA);
        send_item(OP_START, 32'd2, 32'h8000_0001);

        // resume: zero timer fires on the first tick, the paused start on the second
        write_pause(1'b0);
        send_item(OP_TICK, 32'd0, 32'd0);
        send_item(OP_TICK, 32'd0, 32'd0);
        send_item(OP_TICK, 32'd0, 32'd0);
        send_item(OP_START, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_TICK, 32'd0, 32'd0);

        // random phases over pause settings and idle patterns
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_pause(phase_hold[ph] != 0);
            send_idle_pct = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 4 && n == PHASE_ITEMS / 2)
                    wait_idle();
                random_item(phase_pct[ph], phase_fast[ph]);
            end
        end

        // drain with the pause bit cleared again
        write_pause(1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_idle();
        repeat (20) @(posedge clk);

        $display("run covered %0d items and %0d results: %0d expiries, %0d refused starts",
                 sb.n_items, sb.n_checked, sb.n_expired, sb.n_full);
        $display("%0d ticks held while paused, up to %0d expiries on one tick, final tick %0d",
                 sb.n_held_ticks, sb.most_per_tick, sb.tick_count);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
hdl/ost_pkg.sv
hdl/ost_dpath.sv
hdl/ost_ctrl.sv
hdl/one_shot_timer_table.sv
hdl/ost_check.sv
tb/tb_one_shot_timer_table.sv
